FILE: hdl/lubr_pkg.sv
// ----------------------------------------------------------------------------
// lubr_pkg
// shared types and constants of the longest unique byte run block
// ----------------------------------------------------------------------------
package lubr_pkg;

  // byte in, 16-bit length out: these widths are fixed by the interface
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LENGTH_W   = 16;
  // depth of the front-to-back queue and of the result queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]   sym;   // folded table index
    logic [LENGTH_W-1:0] pos;   // position in the string
    logic                skip;  // string ran past the position range
    logic                last;  // final byte of the string
  } lubr_item_t;

  // one result transaction
  typedef struct packed {
    logic [LENGTH_W-1:0] longest_length;
    logic                too_long;
  } lubr_result_t;

endpackage

FILE: hdl/lubr_fifo.sv
// ----------------------------------------------------------------------------
// lubr_fifo
// small register fifo with full and empty flags
// ----------------------------------------------------------------------------
module lubr_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/lubr_front.sv
// ----------------------------------------------------------------------------
// lubr_front
// accepts bytes, folds them onto the table and tags each with its position
// ----------------------------------------------------------------------------
module lubr_front
  import lubr_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              end_of_string_i,
  output logic              full_o,
  // toward the queue
  input  logic              q_full_i,
  output logic              q_push_o,
  output lubr_item_t        q_item_o
);

  localparam int unsigned SymW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned PosW  = (POSITION_BITS > LENGTH_W) ? LENGTH_W : POSITION_BITS;
  localparam logic [PosW-1:0] PosLimit = '1;

  logic [SymW-1:0] fold_tab [256];
  logic [PosW-1:0] pos_q, pos_d;
  logic            accept;
  logic            skip;

  // constant fold table: byte value modulo alphabet size
  for (genvar g = 0; g < 256; g++) begin : g_fold
    localparam int unsigned FoldVal = g % ALPHABET_SIZE;
    assign fold_tab[g] = SymW'(FoldVal);
  end

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  // position counter parks at the limit, so reaching it marks overflow
  assign skip     = (pos_q == PosLimit);

  always_comb begin
    q_item_o      = '0;
    q_item_o.sym  = BYTE_W'(fold_tab[byte_value_i]);
    q_item_o.pos  = LENGTH_W'(pos_q);
    q_item_o.skip = skip;
    q_item_o.last = end_of_string_i;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (end_of_string_i) begin
        pos_d = '0;
      end else if (!skip) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: hdl/lubr_back.sv
// ----------------------------------------------------------------------------
// lubr_back
// last-seen table, sliding window and best length; emits one result per string
// ----------------------------------------------------------------------------
module lubr_back
  import lubr_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // from the queue
  input  logic         q_empty_i,
  input  lubr_item_t   q_item_i,
  output logic         q_pop_o,
  // toward the result queue
  input  logic         r_full_i,
  output logic         r_push_o,
  output lubr_result_t r_data_o
);

  localparam int unsigned SymW = $clog2(ALPHABET_SIZE);
  localparam int unsigned PosW = (POSITION_BITS > LENGTH_W) ? LENGTH_W : POSITION_BITS;

  logic [PosW-1:0]          seen_pos_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] seen_vld_q, seen_vld_d;

  logic            s1_vld_q, s1_vld_d;
  lubr_item_t      s1_q;
  logic [PosW-1:0] rd_pos_q;
  logic            byp_q;
  logic [PosW-1:0] byp_pos_q;
  logic [PosW-1:0] left_q, left_d;
  logic [PosW-1:0] best_q, best_d;

  logic [SymW-1:0] s1_sym, head_sym;
  logic [PosW-1:0] s1_pos, prior_pos, left_n, run, best_n;
  logic            hit, consume, load, wr_en;

  assign s1_sym   = s1_q.sym[SymW-1:0];
  assign s1_pos   = s1_q.pos[PosW-1:0];
  assign head_sym = q_item_i.sym[SymW-1:0];

  // a last byte waits for room in the result queue
  assign consume = s1_vld_q && (!s1_q.last || !r_full_i);
  assign load    = !q_empty_i && (!s1_vld_q || consume);
  assign wr_en   = consume && !s1_q.skip;
  assign q_pop_o = load;

  // window update for the byte in stage one
  assign prior_pos = byp_q ? byp_pos_q : rd_pos_q;
  assign hit       = seen_vld_q[s1_sym] && (prior_pos >= left_q);
  assign left_n    = hit ? prior_pos + 1'b1 : left_q;
  assign run       = s1_pos - left_n + 1'b1;
  assign best_n    = (run > best_q) ? run : best_q;

  assign r_push_o = consume && s1_q.last;
  always_comb begin
    r_data_o.too_long       = s1_q.skip;
    r_data_o.longest_length = s1_q.skip ? '0 : LENGTH_W'(best_n);
  end

  always_comb begin
    left_d     = left_q;
    best_d     = best_q;
    seen_vld_d = seen_vld_q;
    s1_vld_d   = s1_vld_q;
    if (wr_en) begin
      left_d             = left_n;
      best_d             = best_n;
      seen_vld_d[s1_sym] = 1'b1;
    end
    if (consume && s1_q.last) begin
      left_d     = '0;
      best_d     = '0;
      seen_vld_d = '0;
    end
    if (load) begin
      s1_vld_d = 1'b1;
    end else if (consume) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      left_q     <= '0;
      best_q     <= '0;
      seen_vld_q <= '0;
    end else begin
      s1_vld_q   <= s1_vld_d;
      left_q     <= left_d;
      best_q     <= best_d;
      seen_vld_q <= seen_vld_d;
    end
  end

  // stage one payload, read data and write-through bypass
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q      <= q_item_i;
      byp_q     <= wr_en && (s1_sym == head_sym);
      byp_pos_q <= s1_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seen_pos_mem[s1_sym] <= s1_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_pos_q <= seen_pos_mem[head_sym];
    end
  end

endmodule

FILE: hdl/longest_unique_byte_run.sv
// ----------------------------------------------------------------------------
// longest_unique_byte_run
// length of the longest run of bytes without a repeated value, per string
// ----------------------------------------------------------------------------
// usage:
// - input side is a queue: a byte transaction is taken at a rising edge with
//   push high and full low; end_of_string_i marks the final byte of a string
// - result side is a queue: while empty is low the oldest result sits on
//   longest_length_o / too_long_o and leaves at an edge with pop high
// - one result per string, produced by its final byte
// - throughput one byte per cycle unless a final byte waits on a full result
//   queue; the per-byte loop is a single table read plus window and
//   best-length update in the back stage, which pushes into the result queue
// - a stalled result queue holds the back stage on a final byte only; the
//   input queue then fills and full rises; no transaction is lost
// - reset clears all counters, valid bits and queues at once; the position
//   table itself needs no clearing and the block is ready right away
// ----------------------------------------------------------------------------
module longest_unique_byte_run
  import lubr_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte transactions
  input  logic                push,
  output logic                full,
  input  logic [BYTE_W-1:0]   byte_value_i,
  input  logic                end_of_string_i,
  // result transactions
  output logic                empty,
  input  logic                pop,
  output logic [LENGTH_W-1:0] longest_length_o,
  output logic                too_long_o
);

  // front to queue
  logic         fq_push;
  lubr_item_t   fq_item;
  logic         fq_full;
  // queue to back
  logic         bq_empty;
  logic         bq_pop;
  lubr_item_t   bq_item;
  // back to result queue
  logic         r_push;
  logic         r_full;
  lubr_result_t r_data;
  lubr_result_t r_head;

  // front: accept, fold the byte onto the table, tag position and overflow
  lubr_front #(
    .POSITION_BITS (POSITION_BITS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .byte_value_i    (byte_value_i),
    .end_of_string_i (end_of_string_i),
    .full_o          (full),
    .q_full_i        (fq_full),
    .q_push_o        (fq_push),
    .q_item_o        (fq_item)
  );

  // short queue so front and back stall independently
  lubr_fifo #(
    .WIDTH ($bits(lubr_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .data_o  (bq_item),
    .empty_o (bq_empty)
  );

  // back: table lookup, window move, best length
  lubr_back #(
    .POSITION_BITS (POSITION_BITS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (bq_empty),
    .q_item_i  (bq_item),
    .q_pop_o   (bq_pop),
    .r_full_i  (r_full),
    .r_push_o  (r_push),
    .r_data_o  (r_data)
  );

  // result queue doubles as the output register
  lubr_fifo #(
    .WIDTH ($bits(lubr_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .data_i  (r_data),
    .full_o  (r_full),
    .pop_i   (pop),
    .data_o  (r_head),
    .empty_o (empty)
  );

  assign longest_length_o = r_head.longest_length;
  assign too_long_o       = r_head.too_long;

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for longest_unique_byte_run: strings of bytes go in
// through the push/full queue, per-string run lengths come out through the
// empty/pop queue and are checked against a local window tracker
// ----------------------------------------------------------------------------
module testbench;
  import lubr_pkg::*;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned ALPHABET      = 256;
  // longest string that still gives a valid length
  localparam int unsigned POS_LIMIT     = (POSITION_BITS >= 16) ? 65535 :
                                          ((1 << POSITION_BITS) - 1);
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // results trail the final byte through the queues, keep a margin
  localparam int unsigned SETTLE_CYCLES = 12;

  // one pending byte transaction for the driver
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              eos;
    bit                drain;  // hold off until every result is back
    bit                paced;  // allow random gaps after this byte
  } byte_txn_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [BYTE_W-1:0]   byte_value_i = '0;
  logic                end_of_string_i = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [LENGTH_W-1:0] longest_length_o;
  logic                too_long_o;

  byte_txn_t    pending_q[$];
  lubr_result_t run_length_q[$];

  // window tracker state
  int unsigned last_pos [ALPHABET];
  bit          seen     [ALPHABET];
  int unsigned win_left;
  int unsigned cur_pos;
  int unsigned best_run;
  bit          past_limit;

  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned strings_sent = 0;
  int unsigned overflow_strings = 0;
  int unsigned drain_pauses = 0;
  int unsigned longest_seen = 0;
  int unsigned cycle_count = 0;

  // driver and receiver idle control
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;

  longest_unique_byte_run #(
    .POSITION_BITS(POSITION_BITS),
    .ALPHABET_SIZE(ALPHABET)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .byte_value_i    (byte_value_i),
    .end_of_string_i (end_of_string_i),
    .empty           (empty),
    .pop             (pop),
    .longest_length_o(longest_length_o),
    .too_long_o      (too_long_o)
  );

  always #1 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, and now and then a stretch of none
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 2) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // forget the current string, the position table itself stays
  function automatic void clear_string();
    foreach (seen[i]) seen[i] = 1'b0;
    win_left   = 0;
    cur_pos    = 0;
    best_run   = 0;
    past_limit = 1'b0;
  endfunction

  // advance the sliding window by one accepted byte, queue a result on eos
  function automatic void track_byte(logic [BYTE_W-1:0] value, logic eos);
    int unsigned  sym;
    int unsigned  run;
    lubr_result_t res;
    sym = int'(value) % ALPHABET;
    if (past_limit || cur_pos >= POS_LIMIT) begin
      // bytes past the position range only mark the string
      past_limit = 1'b1;
    end else begin
      // a repeat inside the window pushes the left edge past it
      if (seen[sym] && last_pos[sym] >= win_left) win_left = last_pos[sym] + 1;
      last_pos[sym] = cur_pos;
      seen[sym]     = 1'b1;
      run = cur_pos - win_left + 1;
      if (run > best_run) best_run = run;
      cur_pos++;
    end
    if (eos) begin
      res.too_long       = past_limit;
      res.longest_length = past_limit ? '0 : best_run[LENGTH_W-1:0];
      run_length_q = {run_length_q, res};
      strings_sent++;
      if (past_limit) overflow_strings++;
      clear_string();
    end
  endfunction

  task automatic add_byte(input logic [BYTE_W-1:0] value, input logic eos,
                          input bit drain, input bit paced);
    byte_txn_t t;
    t.value = value;
    t.eos   = eos;
    t.drain = drain;
    t.paced = paced;
    pending_q = {pending_q, t};
  endtask

  // driver: presents pending bytes, runs the tracker on every accepted one
  always @(posedge clk_i) begin
    byte_txn_t t;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) track_byte(byte_value_i, end_of_string_i);
      // slot is free once the presented byte went in, or nothing was shown
      if (!push || !full) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (pending_q.size() != 0 && pending_q[0].drain &&
                     run_length_q.size() != 0) begin
          // pause at a string boundary until the result queue is drained
          push <= 1'b0;
        end else if (pending_q.size() != 0) begin
          t = pending_q.pop_front();
          if (t.drain) drain_pauses++;
          push            <= 1'b1;
          byte_value_i    <= t.value;
          end_of_string_i <= t.eos;
          tx_gap = t.paced ? pick_gap(tx_calm) : 0;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: takes results with random stalls, compares with oldest prediction
  always @(posedge clk_i) begin
    lubr_result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (run_length_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual length %0d too_long %0b",
                   $time, longest_length_o, too_long_o);
          errors++;
        end else begin
          want = run_length_q.pop_front();
          results_checked++;
          if (longest_length_o !== want.longest_length) begin
            $display("%0t: longest_length mismatch: expected %0d, actual %0d",
                     $time, want.longest_length, longest_length_o);
            errors++;
          end
          if (too_long_o !== want.too_long) begin
            $display("%0t: too_long mismatch: expected %0b, actual %0b",
                     $time, want.too_long, too_long_o);
            errors++;
          end
          if (!want.too_long && want.longest_length > longest_seen)
            longest_seen = want.longest_length;
        end
        rx_stall = pick_gap(rx_calm);
      end
      if (rx_stall > 0) begin
        pop <= 1'b0;
        rx_stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still outstanding",
               $time, cycle_count, run_length_q.size());
      $display("** longest_unique_byte_run: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned rand_strings;
    int unsigned len;
    int unsigned span;
    int unsigned base;
    int unsigned r;
    bit          drain;

    foreach (last_pos[i]) last_pos[i] = 0;
    clear_string();

    // directed: single-byte strings at both byte extremes
    add_byte(8'h00, 1'b1, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b1, 1'b0, 1'b1);
    // immediate repeat
    add_byte(8'h55, 1'b0, 1'b0, 1'b1);
    add_byte(8'h55, 1'b1, 1'b0, 1'b1);
    // classic repeating pattern, best run of three
    add_byte(8'd1, 1'b0, 1'b0, 1'b1);
    add_byte(8'd2, 1'b0, 1'b0, 1'b1);
    add_byte(8'd3, 1'b0, 1'b0, 1'b1);
    add_byte(8'd1, 1'b0, 1'b0, 1'b1);
    add_byte(8'd2, 1'b0, 1'b0, 1'b1);
    add_byte(8'd3, 1'b0, 1'b0, 1'b1);
    add_byte(8'd2, 1'b0, 1'b0, 1'b1);
    add_byte(8'd2, 1'b1, 1'b0, 1'b1);
    // repeat that lies left of the window must not move the edge back
    add_byte(8'd7, 1'b0, 1'b0, 1'b1);
    add_byte(8'd8, 1'b0, 1'b0, 1'b1);
    add_byte(8'd8, 1'b0, 1'b0, 1'b1);
    add_byte(8'd7, 1'b1, 1'b0, 1'b1);
    // neighbors across the sign bit
    add_byte(8'h80, 1'b0, 1'b0, 1'b1);
    add_byte(8'h7F, 1'b0, 1'b0, 1'b1);
    add_byte(8'h80, 1'b1, 1'b0, 1'b1);
    // every byte value once, the widest possible run, after a full drain
    for (int v = 0; v < 256; v++)
      add_byte(8'(v), v == 255, v == 0, 1'b1);

    // random strings, mostly short with a long tail, narrow and wide alphabets
    rand_items   = 0;
    rand_strings = 0;
    while (rand_items < 370 || rand_strings < 20) begin
      r = $urandom_range(0, 19);
      if (r < 14) len = $urandom_range(1, 8);
      else if (r < 19) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 300);
      case ($urandom_range(0, 4))
        0:       span = 2;
        1:       span = 5;
        2:       span = 16;
        3:       span = 64;
        default: span = 256;
      endcase
      base  = $urandom_range(0, 255);
      drain = (rand_strings == 0) || ($urandom_range(0, 11) == 0);
      for (int i = 0; i < len; i++)
        add_byte(8'(base + $urandom_range(0, span - 1)), i == len - 1,
                 drain && i == 0, 1'b1);
      rand_items += len;
      rand_strings++;
    end

    // a short string at the end must start clean
    add_byte(8'hC3, 1'b0, 1'b0, 1'b1);
    add_byte(8'h3C, 1'b0, 1'b0, 1'b1);
    add_byte(8'hC3, 1'b1, 1'b0, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || push || run_length_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d strings (%0d past the position range), %0d results checked,",
             strings_sent, overflow_strings, results_checked);
    $display("longest run %0d, %0d drain pauses, %0d cycles",
             longest_seen, drain_pauses, cycle_count);
    if (errors == 0 && run_length_q.size() == 0) begin
      $display("** longest_unique_byte_run: PASSED **");
    end else begin
      $display("** longest_unique_byte_run: FAILED **");
    end
    $finish;
  end

endmodule
